// ----- rtl/mtd_pkg.sv -----
// ----------------------------------------------------------------------------
// mtd_pkg
// Shared types, constants and the character code table of the Morse tone
// decoder.
// ----------------------------------------------------------------------------
package mtd_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int RUN_WIDTH_DEF    = 17;
  localparam int MAX_ELEM_DEF     = 7;

  localparam int CFG_WIDTH     = 17;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int CODE_WIDTH    = 8;
  localparam int SYMBOL_WIDTH  = 6;
  localparam int KIND_WIDTH    = 2;
  localparam int FIFO_DEPTH    = 4;

  localparam logic [CODE_WIDTH-1:0] EMPTY_CODE = CODE_WIDTH'(1);

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SHORT_MIN    = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SHORT_MAX    = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_LONG_MIN     = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_LONG_MAX     = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_WORD_GAP_MIN = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_WORD_GAP_MAX = 3'd5;

  // Reset values: 44100 samples/s times 0.1, 0.3, 0.5, 0.7, 1.3 and 1.5 s
  localparam logic [CFG_WIDTH-1:0] RST_SHORT_MIN    = 17'd4410;
  localparam logic [CFG_WIDTH-1:0] RST_SHORT_MAX    = 17'd13230;
  localparam logic [CFG_WIDTH-1:0] RST_LONG_MIN     = 17'd22050;
  localparam logic [CFG_WIDTH-1:0] RST_LONG_MAX     = 17'd30870;
  localparam logic [CFG_WIDTH-1:0] RST_WORD_GAP_MIN = 17'd57330;
  localparam logic [CFG_WIDTH-1:0] RST_WORD_GAP_MAX = 17'd66150;

  typedef enum logic [KIND_WIDTH-1:0] {
    KIND_CHAR    = 2'd0,
    KIND_SPACE   = 2'd1,
    KIND_UNKNOWN = 2'd2
  } mtd_kind_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] short_min;
    logic [CFG_WIDTH-1:0] short_max;
    logic [CFG_WIDTH-1:0] long_min;
    logic [CFG_WIDTH-1:0] long_max;
    logic [CFG_WIDTH-1:0] word_gap_min;
    logic [CFG_WIDTH-1:0] word_gap_max;
  } mtd_cfg_t;

  typedef struct packed {
    mtd_kind_t               kind;
    logic [SYMBOL_WIDTH-1:0] symbol;
    logic [CODE_WIDTH-1:0]   code;
    logic                    last;
  } mtd_result_t;

  typedef struct packed {
    logic        first_valid;
    logic        second_valid;
    mtd_result_t first;
    mtd_result_t second;
  } mtd_emit_t;

  typedef struct packed {
    logic                    hit;
    logic [SYMBOL_WIDTH-1:0] index;
  } mtd_lookup_t;

  // Element code to table index, A first and ampersand last
  function automatic mtd_lookup_t code_lookup(input logic [CODE_WIDTH-1:0] code);
    mtd_lookup_t res;
    res.hit = 1'b1;
    unique case (code)
      8'd5:   res.index = 6'd0;
      8'd45:  res.index = 6'd1;
      8'd24:  res.index = 6'd2;
      8'd26:  res.index = 6'd3;
      8'd52:  res.index = 6'd4;
      8'd12:  res.index = 6'd5;
      8'd2:   res.index = 6'd6;
      8'd41:  res.index = 6'd7;
      8'd36:  res.index = 6'd8;
      8'd18:  res.index = 6'd9;
      8'd14:  res.index = 6'd10;
      8'd16:  res.index = 6'd11;
      8'd4:   res.index = 6'd12;
      8'd23:  res.index = 6'd13;
      8'd13:  res.index = 6'd14;
      8'd20:  res.index = 6'd15;
      8'd7:   res.index = 6'd16;
      8'd6:   res.index = 6'd17;
      8'd15:  res.index = 6'd18;
      8'd22:  res.index = 6'd19;
      8'd29:  res.index = 6'd20;
      8'd10:  res.index = 6'd21;
      8'd8:   res.index = 6'd22;
      8'd3:   res.index = 6'd23;
      8'd9:   res.index = 6'd24;
      8'd17:  res.index = 6'd25;
      8'd11:  res.index = 6'd26;
      8'd25:  res.index = 6'd27;
      8'd27:  res.index = 6'd28;
      8'd28:  res.index = 6'd29;
      8'd47:  res.index = 6'd30;
      8'd39:  res.index = 6'd31;
      8'd35:  res.index = 6'd32;
      8'd33:  res.index = 6'd33;
      8'd32:  res.index = 6'd34;
      8'd48:  res.index = 6'd35;
      8'd56:  res.index = 6'd36;
      8'd60:  res.index = 6'd37;
      8'd62:  res.index = 6'd38;
      8'd63:  res.index = 6'd39;
      8'd85:  res.index = 6'd40;
      8'd115: res.index = 6'd41;
      8'd76:  res.index = 6'd42;
      8'd107: res.index = 6'd43;
      8'd120: res.index = 6'd44;
      8'd106: res.index = 6'd45;
      8'd50:  res.index = 6'd46;
      8'd94:  res.index = 6'd47;
      8'd42:  res.index = 6'd48;
      8'd97:  res.index = 6'd49;
      8'd49:  res.index = 6'd50;
      8'd54:  res.index = 6'd51;
      8'd109: res.index = 6'd52;
      8'd77:  res.index = 6'd53;
      8'd137: res.index = 6'd54;
      8'd90:  res.index = 6'd55;
      8'd40:  res.index = 6'd56;
      default: begin
        res.hit   = 1'b0;
        res.index = '0;
      end
    endcase
    return res;
  endfunction

endpackage

// ----- rtl/morse_tone_decoder_top.sv -----
// ----------------------------------------------------------------------------
// morse_tone_decoder_top
// Morse tone decoder: classes tone and silence runs of an audio sample stream
// and reports characters, word spaces and unknown codes.
// ----------------------------------------------------------------------------
// The decoder takes one audio sample per clock cycle while in_stall is low.
// Each accepted sample updates the run counters and element code in that
// same cycle, and any result words it causes sit in a four-word output queue
// from the next cycle on. A letter gap or an end-of-stream flush yields one
// word; a word gap yields two (the character, then a word space), with
// out_last marking the final word of a sample. in_stall rises while the
// queue has fewer than two free words, so the input keeps its
// one-sample-per-cycle rate as long as the output side drains. Window
// registers should be written only while the block is idle.
module morse_tone_decoder_top #(
  parameter int SAMPLE_WIDTH      = mtd_pkg::SAMPLE_WIDTH_DEF,
  parameter int RUN_COUNTER_WIDTH = mtd_pkg::RUN_WIDTH_DEF,
  parameter int MAX_ELEMENTS      = mtd_pkg::MAX_ELEM_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_wr_en,
  input  logic [mtd_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [mtd_pkg::CFG_WIDTH-1:0]     cfg_wdata,
  // sample input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_sample,
  input  logic                              in_end_of_stream,
  // result output
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mtd_pkg::KIND_WIDTH-1:0]    out_kind,
  output logic [mtd_pkg::SYMBOL_WIDTH-1:0]  out_symbol,
  output logic [mtd_pkg::CODE_WIDTH-1:0]    out_code,
  output logic                              out_last
);
  import mtd_pkg::*;

  mtd_cfg_t    cfg;
  mtd_emit_t   emit;
  mtd_result_t out_word;
  logic        no_room;
  logic        in_accept;

  // Accept a sample whenever the queue can take the worst case of two words
  assign in_stall  = no_room;
  assign in_accept = in_valid && !no_room;

  mtd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Only zero versus nonzero matters to the tracker
  mtd_tracker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .RUN_WIDTH    (RUN_COUNTER_WIDTH),
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_tracker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_accept     (in_accept),
    .sample        (in_sample),
    .end_of_stream (in_end_of_stream),
    .cfg           (cfg),
    .emit          (emit)
  );

  mtd_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (emit),
    .no_room   (no_room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // Unpack the head word onto the result ports
  assign out_kind   = out_word.kind;
  assign out_symbol = out_word.symbol;
  assign out_code   = out_word.code;
  assign out_last   = out_word.last;

endmodule

// ----- rtl/mtd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// mtd_cfg_regs
// Window threshold registers, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module mtd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [mtd_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [mtd_pkg::CFG_WIDTH-1:0]     cfg_wdata,
  output mtd_pkg::mtd_cfg_t                 cfg
);
  import mtd_pkg::*;

  mtd_cfg_t cfg_r;
  mtd_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SHORT_MIN:    cfg_nxt.short_min    = cfg_wdata;
        CFG_SHORT_MAX:    cfg_nxt.short_max    = cfg_wdata;
        CFG_LONG_MIN:     cfg_nxt.long_min     = cfg_wdata;
        CFG_LONG_MAX:     cfg_nxt.long_max     = cfg_wdata;
        CFG_WORD_GAP_MIN: cfg_nxt.word_gap_min = cfg_wdata;
        CFG_WORD_GAP_MAX: cfg_nxt.word_gap_max = cfg_wdata;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_min    <= RST_SHORT_MIN;
      cfg_r.short_max    <= RST_SHORT_MAX;
      cfg_r.long_min     <= RST_LONG_MIN;
      cfg_r.long_max     <= RST_LONG_MAX;
      cfg_r.word_gap_min <= RST_WORD_GAP_MIN;
      cfg_r.word_gap_max <= RST_WORD_GAP_MAX;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/mtd_tracker.sv -----
// ----------------------------------------------------------------------------
// mtd_tracker
// Run counters, run classification, element code register and result
// formation for one sample per cycle while in_accept is high.
// ----------------------------------------------------------------------------
module mtd_tracker #(
  parameter int SAMPLE_WIDTH = mtd_pkg::SAMPLE_WIDTH_DEF,
  parameter int RUN_WIDTH    = mtd_pkg::RUN_WIDTH_DEF,
  parameter int MAX_ELEMENTS = mtd_pkg::MAX_ELEM_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_accept,
  input  logic [SAMPLE_WIDTH-1:0] sample,
  input  logic                    end_of_stream,
  input  mtd_pkg::mtd_cfg_t       cfg,
  output mtd_pkg::mtd_emit_t      emit
);
  import mtd_pkg::*;

  localparam int CMP_WIDTH = (RUN_WIDTH > CFG_WIDTH) ? RUN_WIDTH : CFG_WIDTH;

  logic                  prev_zero_r, prev_zero_nxt;
  logic                  first_seen_r, first_seen_nxt;
  logic [RUN_WIDTH-1:0]  silence_r, silence_nxt;
  logic [RUN_WIDTH-1:0]  tone_r, tone_nxt;
  logic [CODE_WIDTH-1:0] code_r, code_nxt;
  logic                  ovf_r, ovf_nxt;

  logic                  is_zero;
  logic                  append_en, append_dash;
  logic                  gap_emit, word_gap, eos_emit;
  logic [CODE_WIDTH-1:0] code_mid;
  logic                  ovf_mid;

  function automatic logic in_window(input logic [RUN_WIDTH-1:0] run,
                                     input logic [CFG_WIDTH-1:0] lo,
                                     input logic [CFG_WIDTH-1:0] hi);
    logic [CMP_WIDTH-1:0] v;
    v = CMP_WIDTH'(run);
    return (v > CMP_WIDTH'(lo)) && (v < CMP_WIDTH'(hi));
  endfunction

  function automatic mtd_result_t make_char(input logic [CODE_WIDTH-1:0] code,
                                            input logic ovf, input logic last);
    mtd_result_t res;
    mtd_lookup_t lk;
    lk = code_lookup(code);
    res.code = code;
    res.last = last;
    if (lk.hit && !ovf) begin
      res.kind   = KIND_CHAR;
      res.symbol = lk.index;
    end else begin
      res.kind   = KIND_UNKNOWN;
      res.symbol = '0;
    end
    return res;
  endfunction

  assign is_zero = (sample == '0);

  always_comb begin
    prev_zero_nxt  = prev_zero_r;
    first_seen_nxt = first_seen_r;
    silence_nxt    = silence_r;
    tone_nxt       = tone_r;
    append_en      = 1'b0;
    append_dash    = 1'b0;
    gap_emit       = 1'b0;
    word_gap       = 1'b0;

    if (!first_seen_r) begin
      first_seen_nxt = 1'b1;
    end else if (is_zero && prev_zero_r) begin
      if (silence_r != '1) silence_nxt = silence_r + 1'b1;
      if (tone_r != '0) begin
        if (in_window(tone_r, cfg.short_min, cfg.short_max)) begin
          append_en = 1'b1;
        end else if (in_window(tone_r, cfg.long_min, cfg.long_max)) begin
          append_en   = 1'b1;
          append_dash = 1'b1;
        end
        tone_nxt = '0;
      end
    end else if (!is_zero && !prev_zero_r) begin
      if (tone_r != '1) tone_nxt = tone_r + 1'b1;
      if (silence_r != '0) begin
        if (in_window(silence_r, cfg.short_min, cfg.short_max)) begin
          // gap inside a character
        end else if (in_window(silence_r, cfg.long_min, cfg.long_max)) begin
          gap_emit = 1'b1;
        end else if (in_window(silence_r, cfg.word_gap_min, cfg.word_gap_max)) begin
          gap_emit = 1'b1;
          word_gap = 1'b1;
        end
        silence_nxt = '0;
      end
    end
    prev_zero_nxt = is_zero;

    code_mid = code_r;
    ovf_mid  = ovf_r;
    if (append_en) begin
      if ((code_r >> MAX_ELEMENTS) != '0) begin
        ovf_mid = 1'b1;
      end else begin
        code_mid = {code_r[CODE_WIDTH-2:0], append_dash};
      end
    end
    if (gap_emit) begin
      code_mid = EMPTY_CODE;
      ovf_mid  = 1'b0;
    end

    // A gap leaves the code empty, so a flush never follows a gap result
    eos_emit = end_of_stream && ((code_mid != EMPTY_CODE) || ovf_mid);

    emit.first_valid  = in_accept && (gap_emit || eos_emit);
    emit.first        = gap_emit ? make_char(code_r, ovf_r, !word_gap)
                                 : make_char(code_mid, ovf_mid, 1'b1);
    emit.second_valid = in_accept && word_gap;
    emit.second.kind   = KIND_SPACE;
    emit.second.symbol = '0;
    emit.second.code   = EMPTY_CODE;
    emit.second.last   = 1'b1;

    code_nxt = code_mid;
    ovf_nxt  = ovf_mid;
    if (end_of_stream) begin
      prev_zero_nxt  = 1'b0;
      first_seen_nxt = 1'b0;
      silence_nxt    = '0;
      tone_nxt       = '0;
      code_nxt       = EMPTY_CODE;
      ovf_nxt        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_zero_r  <= 1'b0;
      first_seen_r <= 1'b0;
      silence_r    <= '0;
      tone_r       <= '0;
      code_r       <= EMPTY_CODE;
      ovf_r        <= 1'b0;
    end else if (in_accept) begin
      prev_zero_r  <= prev_zero_nxt;
      first_seen_r <= first_seen_nxt;
      silence_r    <= silence_nxt;
      tone_r       <= tone_nxt;
      code_r       <= code_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

endmodule

// ----- rtl/mtd_out_fifo.sv -----
// ----------------------------------------------------------------------------
// mtd_out_fifo
// Result queue: per cycle, up to two words in and one out unless stalled.
// ----------------------------------------------------------------------------
module mtd_out_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mtd_pkg::mtd_emit_t   emit,
  output logic                 no_room,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mtd_pkg::mtd_result_t out_word
);
  import mtd_pkg::*;

  localparam int PTR_WIDTH   = $clog2(FIFO_DEPTH);
  localparam int COUNT_WIDTH = $clog2(FIFO_DEPTH + 1);

  mtd_result_t            mem_r [FIFO_DEPTH];
  logic [PTR_WIDTH-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_WIDTH-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [PTR_WIDTH-1:0]   wr_ptr_second;
  logic [1:0]             push_n;
  logic                   pop;

  assign push_n        = {1'b0, emit.first_valid} + {1'b0, emit.second_valid};
  assign pop           = (count_r != '0) && !out_stall;
  assign wr_ptr_second = wr_ptr_r + 1'b1;
  assign wr_ptr_nxt    = wr_ptr_r + PTR_WIDTH'(push_n);
  assign rd_ptr_nxt    = rd_ptr_r + PTR_WIDTH'(pop);
  assign count_nxt     = count_r + COUNT_WIDTH'(push_n) - COUNT_WIDTH'(pop);

  // Hold off input while a two-word item might not fit
  assign no_room   = count_r > COUNT_WIDTH'(FIFO_DEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_word  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (emit.first_valid)  mem_r[wr_ptr_r]      <= emit.first;
    if (emit.second_valid) mem_r[wr_ptr_second] <= emit.second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
